>>> hw/rtl/lti_pkg.sv
// ----------------------------------------------------------------------------
// lti_pkg
// Types and constants shared by the lap trace interpolator files.
// ----------------------------------------------------------------------------
package lti_pkg;

    localparam int PROG_W   = 17;
    localparam int TIME_W   = 24;
    localparam int VAL_W    = 16;
    localparam int POS_W    = 24;
    localparam int TDATA_W  = 160;
    localparam int OPW      = 26;   // common signed operand width for lerp
    localparam int NSW      = 25;   // width of fraction numerator and span
    localparam int QW       = 26;   // quotient bits produced by the divider
    localparam int NUMW     = 56;   // lerp numerator width

    localparam logic [PROG_W-1:0] FULL_LAP = 17'd65536;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QPROG  = 2'd2,
        ACT_QTIME  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        F_PROG  = 3'd0,
        F_TIME  = 3'd1,
        F_SPEED = 3'd2,
        F_GLAT  = 3'd3,
        F_GLONG = 3'd4,
        F_ACCEL = 3'd5,
        F_X     = 3'd6,
        F_Y     = 3'd7
    } t_fld;

    // progress sits in the lowest bits
    typedef struct packed {
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  x;
        logic signed [VAL_W-1:0]  accel;
        logic signed [VAL_W-1:0]  glong;
        logic signed [VAL_W-1:0]  glat;
        logic signed [VAL_W-1:0]  speed;
        logic        [TIME_W-1:0] tms;
        logic        [PROG_W-1:0] prog;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BS,
        S_BSC,
        S_PF,
        S_PL,
        S_PM1,
        S_PM2,
        S_TSA,
        S_TSB,
        S_LSEL,
        S_DVI,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

    function automatic logic signed [OPW-1:0] f_operand(input t_entry e, input t_fld f);
        logic signed [OPW-1:0] v;
        unique case (f)
            F_PROG:  v = $signed(OPW'(e.prog));
            F_TIME:  v = $signed(OPW'(e.tms));
            F_SPEED: v = OPW'(e.speed);
            F_GLAT:  v = OPW'(e.glat);
            F_GLONG: v = OPW'(e.glong);
            F_ACCEL: v = OPW'(e.accel);
            F_X:     v = OPW'(e.x);
            F_Y:     v = OPW'(e.y);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/lti_ram.sv
// ----------------------------------------------------------------------------
// lti_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/lap_trace_interpolator_unit.sv
// ----------------------------------------------------------------------------
// lap_trace_interpolator_unit
// Sample table of one lap with lookup and linear interpolation by progress
// or by time.
// ----------------------------------------------------------------------------
// Usage:
//  Slave stream: tuser carries the action (clear, append, query by progress,
//  query by time), tdata the sample or query fields. Clear and append beats
//  give no result; each query gives exactly one master beat, tuser[0] being
//  the found flag and tdata the result (all zero when not found).
//  A progress query runs a binary search over the table memory, each probe
//  reading the middle entry and then narrowing the range, then the lerp of
//  up to five fields. A time query scans the memory one entry a cycle until
//  the matching pair, then lerps up to four fields. Each lerp registers the
//  product numerator, then runs a restoring divider for 26 quotient bits and
//  writes the field back; the search and scan use the single table memory
//  read port and all fields share one divider. One beat is worked on at a
//  time: the slave side is ready again once the result beat has been taken.
//  Reset empties the table and loads the register defaults. A stalled master
//  side holds the result and keeps the slave side not ready.
//  Registers via APB: lap time in ms at address 0, edge tolerance (Q1.16) at address 4.
// ----------------------------------------------------------------------------
module lap_trace_interpolator_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // progress, time_ms, speed, g_lateral, g_longitudinal, accel, pos_x, pos_y
    input  logic [lti_pkg::TDATA_W-1:0] i_s_tdata,
    // action
    input  logic [1:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // out_progress, out_time_ms, out_speed, out_g_lateral, out_g_longitudinal,
    // out_accel, out_x, out_y
    output logic [lti_pkg::TDATA_W-1:0] o_m_tdata,
    // found
    output logic [0:0]                  o_m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int EW = $bits(lti_pkg::t_entry);
    localparam int RW = lti_pkg::OPW;

    lti_pkg::t_state  r_state, n_state;
    logic [23:0]      r_lap_ms;
    logic [16:0]      r_tol;
    logic [CW-1:0]    r_count;

    logic [lti_pkg::PROG_W-1:0] r_first_prog, r_last_prog, r_qprog;
    logic [lti_pkg::TIME_W-1:0] r_first_time, r_last_time, r_qtime;
    logic [CW-1:0]    r_lo, r_hi, r_mid, r_idx;
    lti_pkg::t_entry  r_ea, r_eb, r_out;
    logic             r_found;
    logic [7:0]       r_lmask;
    lti_pkg::t_fld    r_fld;
    logic signed [lti_pkg::OPW-1:0]  r_a;
    logic [lti_pkg::NSW-1:0]         r_n, r_s;
    logic signed [lti_pkg::NUMW-1:0] r_num;
    logic             r_neg;
    logic [RW-1:0]    r_rem;
    logic [lti_pkg::QW-1:0] r_quo;
    logic [4:0]       r_cnt;

    lti_pkg::t_entry  in_e, ram_q;
    lti_pkg::t_action in_act;
    logic             accept, app_ok, prog_nf, time_nf;
    logic [AW-1:0]    ram_raddr;
    logic [CW-1:0]    mid, idx_nx;
    logic             ts_match, span_pos;

    assign in_e   = lti_pkg::t_entry'(i_s_tdata[EW-1:0]);
    assign in_act = lti_pkg::t_action'(i_s_tuser);
    assign accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == lti_pkg::S_IDLE);

    assign app_ok = (r_count < CW'(MAX_SAMPLES)) &&
                    ((r_count == '0) || (in_e.prog >= r_last_prog));
    assign prog_nf = (r_count == '0) ||
                     ({1'b0, in_e.prog} + {1'b0, r_tol} < {1'b0, r_first_prog}) ||
                     ({1'b0, in_e.prog} > {1'b0, r_last_prog} + {1'b0, r_tol});
    assign time_nf = (r_count == '0) || (in_e.tms < r_first_time) ||
                     (in_e.tms > r_last_time);

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_nx   = r_idx + CW'(1);
    assign ts_match = (r_ea.tms <= r_qtime) && (r_qtime <= ram_q.tms);
    assign span_pos = (ram_q.prog > r_ea.prog);

    lti_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SAMPLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && (in_act == lti_pkg::ACT_APPEND) && app_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (in_e),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {15'd0, r_tol} : {8'd0, r_lap_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lti_pkg::S_IDLE;
            r_count    <= '0;
            r_lap_ms   <= '0;
            r_tol      <= 17'd328;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                if (paddr[2]) begin
                    r_tol <= pwdata[16:0];
                end else begin
                    r_lap_ms <= pwdata[23:0];
                end
            end
            if (accept && (in_act == lti_pkg::ACT_CLEAR)) begin
                r_count <= '0;
            end else if (accept && (in_act == lti_pkg::ACT_APPEND) && app_ok) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_raddr = '0;
        unique case (r_state)
            lti_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (in_act)
                        lti_pkg::ACT_QPROG: n_state = prog_nf ? lti_pkg::S_OUT : lti_pkg::S_BS;
                        lti_pkg::ACT_QTIME: n_state = time_nf ? lti_pkg::S_OUT : lti_pkg::S_TSA;
                        default:            n_state = lti_pkg::S_IDLE;
                    endcase
                end
            end
            lti_pkg::S_BS: begin
                if (r_lo < r_hi) begin
                    ram_raddr = mid[AW-1:0];
                    n_state   = lti_pkg::S_BSC;
                end else if (r_lo == '0) begin
                    n_state = lti_pkg::S_PF;
                end else if (r_lo >= r_count) begin
                    ram_raddr = AW'(r_count - CW'(1));
                    n_state   = lti_pkg::S_PL;
                end else begin
                    ram_raddr = AW'(r_lo - CW'(1));
                    n_state   = lti_pkg::S_PM1;
                end
            end
            lti_pkg::S_BSC: n_state = lti_pkg::S_BS;
            lti_pkg::S_PF:  n_state = lti_pkg::S_OUT;
            lti_pkg::S_PL: begin
                n_state = (r_lap_ms > ram_q.tms) ? lti_pkg::S_LSEL : lti_pkg::S_OUT;
            end
            lti_pkg::S_PM1: begin
                ram_raddr = r_lo[AW-1:0];
                n_state   = lti_pkg::S_PM2;
            end
            lti_pkg::S_PM2: n_state = span_pos ? lti_pkg::S_LSEL : lti_pkg::S_OUT;
            lti_pkg::S_TSA: begin
                if (r_idx < r_count) begin
                    ram_raddr = r_idx[AW-1:0];
                    n_state   = lti_pkg::S_TSB;
                end else begin
                    n_state = lti_pkg::S_OUT;
                end
            end
            lti_pkg::S_TSB: begin
                if (ts_match) begin
                    n_state = (ram_q.tms > r_ea.tms) ? lti_pkg::S_LSEL : lti_pkg::S_OUT;
                end else if (idx_nx < r_count) begin
                    ram_raddr = idx_nx[AW-1:0];
                end else begin
                    n_state = lti_pkg::S_OUT;
                end
            end
            lti_pkg::S_LSEL: n_state = (r_lmask == '0) ? lti_pkg::S_OUT : lti_pkg::S_DVI;
            lti_pkg::S_DVI:  n_state = lti_pkg::S_DIV;
            lti_pkg::S_DIV: begin
                if (r_cnt == 5'(lti_pkg::QW - 1)) begin
                    n_state = lti_pkg::S_WB;
                end
            end
            lti_pkg::S_WB:  n_state = lti_pkg::S_LSEL;
            lti_pkg::S_OUT: begin
                if (i_m_tready) begin
                    n_state = lti_pkg::S_IDLE;
                end
            end
            default: n_state = lti_pkg::S_IDLE;
        endcase
    end

    // lerp datapath
    lti_pkg::t_fld                    sel_f;
    logic signed [lti_pkg::OPW-1:0]   op_a, op_b;
    logic signed [lti_pkg::OPW:0]     w_diff, w_nsig;
    logic signed [2*lti_pkg::OPW+1:0] w_prod;
    logic signed [lti_pkg::NUMW-1:0]  w_num, w_mag;
    logic [RW:0]                      rem2;
    logic [RW-1:0]                    dvs;
    logic                             ge;
    logic signed [RW:0]               qs;
    logic signed [RW+1:0]             w_val;
    logic [lti_pkg::PROG_W-1:0]       pl_sp, pl_nn;

    always_comb begin
        sel_f = lti_pkg::F_PROG;
        for (int k = 7; k >= 0; k--) begin
            if (r_lmask[k]) begin
                sel_f = lti_pkg::t_fld'(3'(k));
            end
        end
    end

    assign op_a   = lti_pkg::f_operand(r_ea, sel_f);
    assign op_b   = lti_pkg::f_operand(r_eb, sel_f);
    assign w_diff = (lti_pkg::OPW+1)'(op_b) - (lti_pkg::OPW+1)'(op_a);
    assign w_nsig = $signed((lti_pkg::OPW+1)'(r_n));
    assign w_prod = w_diff * w_nsig;
    assign w_num  = (lti_pkg::NUMW'(w_prod) <<< 1) + $signed(lti_pkg::NUMW'(r_s));
    assign w_mag  = r_num[lti_pkg::NUMW-1] ? -r_num : r_num;

    assign dvs  = {r_s, 1'b0};
    assign rem2 = {r_rem, r_quo[lti_pkg::QW-1]};
    assign ge   = (rem2 >= {1'b0, dvs});

    // floor division: negative numerators round away once a remainder is left
    assign qs    = r_neg ? -($signed({1'b0, r_quo}) + $signed((RW+1)'(r_rem != '0)))
                         : $signed({1'b0, r_quo});
    assign w_val = (RW+2)'(r_a) + (RW+2)'(qs);

    assign pl_sp = lti_pkg::FULL_LAP - ram_q.prog;
    assign pl_nn = r_qprog - ram_q.prog;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lti_pkg::S_IDLE: begin
                if (accept) begin
                    r_qprog <= in_e.prog;
                    r_qtime <= in_e.tms;
                    r_lo    <= '0;
                    r_hi    <= r_count;
                    r_idx   <= CW'(1);
                    r_out   <= '0;
                    r_found <= 1'b0;
                    r_lmask <= '0;
                    if ((in_act == lti_pkg::ACT_APPEND) && app_ok) begin
                        r_last_prog <= in_e.prog;
                        r_last_time <= in_e.tms;
                        if (r_count == '0) begin
                            r_first_prog <= in_e.prog;
                            r_first_time <= in_e.tms;
                        end
                    end
                end
            end
            lti_pkg::S_BS: r_mid <= mid;
            lti_pkg::S_BSC: begin
                if (ram_q.prog < r_qprog) begin
                    r_lo <= r_mid + CW'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            lti_pkg::S_PF: begin
                r_out   <= ram_q;
                r_found <= 1'b1;
            end
            lti_pkg::S_PL: begin
                r_out      <= lti_pkg::t_entry'({ram_q[EW-1:lti_pkg::PROG_W], r_qprog});
                r_found    <= 1'b1;
                r_ea       <= ram_q;
                r_eb       <= lti_pkg::t_entry'({ram_q[EW-1:lti_pkg::PROG_W+lti_pkg::TIME_W],
                                                 r_lap_ms, ram_q.prog});
                r_lmask    <= 8'(1) << lti_pkg::F_TIME;
                if (ram_q.prog >= lti_pkg::FULL_LAP) begin
                    r_n <= lti_pkg::NSW'(1);
                    r_s <= lti_pkg::NSW'(1);
                end else begin
                    r_s <= lti_pkg::NSW'(pl_sp);
                    r_n <= lti_pkg::NSW'((pl_nn > pl_sp) ? pl_sp : pl_nn);
                end
            end
            lti_pkg::S_PM1: r_ea <= ram_q;
            lti_pkg::S_PM2: begin
                r_eb       <= ram_q;
                r_out      <= lti_pkg::t_entry'({r_ea[EW-1:lti_pkg::PROG_W], r_qprog});
                r_found    <= 1'b1;
                r_n        <= lti_pkg::NSW'(r_qprog - r_ea.prog);
                r_s        <= lti_pkg::NSW'(ram_q.prog - r_ea.prog);
                r_lmask    <= 8'b0011_1110;
            end
            lti_pkg::S_TSA: r_ea <= ram_q;
            lti_pkg::S_TSB: begin
                if (ts_match) begin
                    r_eb      <= ram_q;
                    r_out     <= lti_pkg::t_entry'({r_ea[EW-1:lti_pkg::PROG_W+lti_pkg::TIME_W],
                                                    r_qtime, r_ea.prog});
                    r_found   <= 1'b1;
                    r_n       <= lti_pkg::NSW'(r_qtime - r_ea.tms);
                    r_s       <= lti_pkg::NSW'(ram_q.tms - r_ea.tms);
                    r_lmask   <= 8'b1100_0101;
                end else begin
                    r_ea  <= ram_q;
                    r_idx <= idx_nx;
                end
            end
            lti_pkg::S_LSEL: begin
                if (r_lmask != '0) begin
                    r_fld          <= sel_f;
                    r_lmask[sel_f] <= 1'b0;
                    r_a            <= op_a;
                    r_num          <= w_num;
                end
            end
            lti_pkg::S_DVI: begin
                r_neg <= r_num[lti_pkg::NUMW-1];
                r_rem <= w_mag[lti_pkg::QW +: RW];
                r_quo <= w_mag[lti_pkg::QW-1:0];
                r_cnt <= '0;
            end
            lti_pkg::S_DIV: begin
                r_rem <= ge ? RW'(rem2 - {1'b0, dvs}) : RW'(rem2);
                r_quo <= {r_quo[lti_pkg::QW-2:0], ge};
                r_cnt <= r_cnt + 5'd1;
            end
            lti_pkg::S_WB: begin
                case (r_fld)
                    lti_pkg::F_PROG:  r_out.prog  <= w_val[lti_pkg::PROG_W-1:0];
                    lti_pkg::F_TIME:  r_out.tms   <= w_val[lti_pkg::TIME_W-1:0];
                    lti_pkg::F_SPEED: r_out.speed <= w_val[lti_pkg::VAL_W-1:0];
                    lti_pkg::F_GLAT:  r_out.glat  <= w_val[lti_pkg::VAL_W-1:0];
                    lti_pkg::F_GLONG: r_out.glong <= w_val[lti_pkg::VAL_W-1:0];
                    lti_pkg::F_ACCEL: r_out.accel <= w_val[lti_pkg::VAL_W-1:0];
                    lti_pkg::F_X:     r_out.x     <= w_val[lti_pkg::POS_W-1:0];
                    lti_pkg::F_Y:     r_out.y     <= w_val[lti_pkg::POS_W-1:0];
                    default:          r_out.prog  <= r_out.prog;
                endcase
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_m_tvalid = (r_state == lti_pkg::S_OUT);
    assign o_m_tdata  = {(lti_pkg::TDATA_W - EW)'(0), r_out};
    assign o_m_tuser  = r_found;

endmodule

>>> hw/rtl/lti_checker.sv
// ----------------------------------------------------------------------------
// lti_checker
// Port-level checks on the lap trace interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module lti_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [lti_pkg::TDATA_W-1:0] o_m_tdata,
    input logic [0:0]                  o_m_tuser,
    input logic                        pready
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result beat changed under stall");

    // one beat in work at a time
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("slave ready while a result is pending");

    // a miss carries an all-zero payload
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata == '0))
        else $error("miss with non-zero payload");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind lap_trace_interpolator_unit lti_checker u_lti_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);

>>> tb/lap_trace_interpolator_unit_test.sv
// ----------------------------------------------------------------------------
// lap_trace_interpolator_unit_test
// Self-checking bench for the lap trace interpolator: builds sample tables
// over the slave stream, queries them by progress and by time, and checks
// every result beat against a predictor of its own under varied idling,
// stalls and register settings.
// ----------------------------------------------------------------------------
module lap_trace_interpolator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_LAP_MS   = 3'd0;
    localparam logic [2:0] ADDR_EDGE_TOL = 3'd4;
    localparam int         TABLE_DEPTH   = 1024;
    localparam int         SETTLE_CYCLES = 1400;

    typedef struct {
        lti_pkg::t_action                  act;
        logic        [lti_pkg::PROG_W-1:0] prog;
        logic        [lti_pkg::TIME_W-1:0] tms;
        logic signed [lti_pkg::VAL_W-1:0]  speed;
        logic signed [lti_pkg::VAL_W-1:0]  glat;
        logic signed [lti_pkg::VAL_W-1:0]  glong;
        logic signed [lti_pkg::VAL_W-1:0]  accel;
        logic signed [lti_pkg::POS_W-1:0]  x;
        logic signed [lti_pkg::POS_W-1:0]  y;
    } t_lap_item;

    typedef struct {
        bit                         found;
        bit [lti_pkg::PROG_W-1:0]   prog;
        bit [lti_pkg::TIME_W-1:0]   tms;
        bit [lti_pkg::VAL_W-1:0]    speed;
        bit [lti_pkg::VAL_W-1:0]    glat;
        bit [lti_pkg::VAL_W-1:0]    glong;
        bit [lti_pkg::VAL_W-1:0]    accel;
        bit [lti_pkg::POS_W-1:0]    x;
        bit [lti_pkg::POS_W-1:0]    y;
    } t_lookup;

    // ------------------------------------------------------------------------
    class lap_table_scoreboard;
        longint  lap_ms;
        longint  edge_tol;
        int      count;
        longint  p_tab[TABLE_DEPTH];
        longint  t_tab[TABLE_DEPTH];
        longint  v_tab[TABLE_DEPTH][6];   // speed, glat, glong, accel, x, y
        t_lookup pending[$];
        int      errors;

        function new();
            lap_ms   = 0;
            edge_tol = 328;
            count    = 0;
            errors   = 0;
        endfunction

        static function longint lerp(longint a, longint b, longint n, longint s);
            longint num;
            longint den;
            longint q;
            num = 2 * (b - a) * n + s;
            den = 2 * s;
            q   = num / den;
            if ((num % den) != 0 && num < 0) q--;
            return a + q;
        endfunction

        function t_lookup sample_at(int i);
            t_lookup r;
            r.found = 1;
            r.prog  = p_tab[i];
            r.tms   = t_tab[i];
            r.speed = v_tab[i][0];
            r.glat  = v_tab[i][1];
            r.glong = v_tab[i][2];
            r.accel = v_tab[i][3];
            r.x     = v_tab[i][4];
            r.y     = v_tab[i][5];
            return r;
        endfunction

        function t_lookup by_progress(longint d);
            t_lookup r;
            int      lo;
            int      hi;
            int      mid;
            int      last;
            longint  n;
            longint  sp;
            longint  span;
            r = '{default: 0};
            if (count == 0) return r;
            last = count - 1;
            if (d + edge_tol < p_tab[0] || d > p_tab[last] + edge_tol) return r;
            lo = 0;
            hi = count;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (p_tab[mid] < d) lo = mid + 1; else hi = mid;
            end
            if (lo == 0) return sample_at(0);
            if (lo >= count) begin
                r      = sample_at(last);
                r.prog = d;
                if (lap_ms > t_tab[last]) begin
                    sp = 65536 - p_tab[last];
                    n  = d - p_tab[last];
                    if (sp <= 0) begin
                        n  = 1;
                        sp = 1;
                    end else if (n > sp) begin
                        n = sp;
                    end
                    r.tms = lerp(t_tab[last], lap_ms, n, sp);
                end
                return r;
            end
            r      = sample_at(lo - 1);
            r.prog = d;
            span   = p_tab[lo] - p_tab[lo-1];
            if (span > 0) begin
                n       = d - p_tab[lo-1];
                r.tms   = lerp(t_tab[lo-1], t_tab[lo], n, span);
                r.speed = lerp(v_tab[lo-1][0], v_tab[lo][0], n, span);
                r.glat  = lerp(v_tab[lo-1][1], v_tab[lo][1], n, span);
                r.glong = lerp(v_tab[lo-1][2], v_tab[lo][2], n, span);
                r.accel = lerp(v_tab[lo-1][3], v_tab[lo][3], n, span);
            end
            return r;
        endfunction

        function t_lookup by_time(longint s);
            t_lookup r;
            longint  n;
            longint  span;
            r = '{default: 0};
            if (count == 0) return r;
            if (s < t_tab[0] || s > t_tab[count-1]) return r;
            for (int i = 1; i < count; i++) begin
                if (s < t_tab[i-1] || s > t_tab[i]) continue;
                r     = sample_at(i - 1);
                r.tms = s;
                span  = t_tab[i] - t_tab[i-1];
                if (span > 0) begin
                    n       = s - t_tab[i-1];
                    r.prog  = lerp(p_tab[i-1], p_tab[i], n, span);
                    r.speed = lerp(v_tab[i-1][0], v_tab[i][0], n, span);
                    r.x     = lerp(v_tab[i-1][4], v_tab[i][4], n, span);
                    r.y     = lerp(v_tab[i-1][5], v_tab[i][5], n, span);
                end
                return r;
            end
            return r;
        endfunction

        function void note_input(t_lap_item it);
            case (it.act)
                lti_pkg::ACT_CLEAR:  count = 0;
                lti_pkg::ACT_APPEND: begin
                    if (count < TABLE_DEPTH && !(count > 0 && it.prog < p_tab[count-1])) begin
                        p_tab[count]    = it.prog;
                        t_tab[count]    = it.tms;
                        v_tab[count][0] = it.speed;
                        v_tab[count][1] = it.glat;
                        v_tab[count][2] = it.glong;
                        v_tab[count][3] = it.accel;
                        v_tab[count][4] = it.x;
                        v_tab[count][5] = it.y;
                        count++;
                    end
                end
                lti_pkg::ACT_QPROG:  pending.push_back(by_progress(it.prog));
                default:             pending.push_back(by_time(it.tms));
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(bit found, bit [lti_pkg::TDATA_W-1:0] data);
            t_lookup e;
            t_lookup g;
            if (pending.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            g.found = found;
            {g.y, g.x, g.accel, g.glong, g.glat, g.speed, g.tms, g.prog} = data[152:0];
            if (g.found !== e.found) report($sformatf("found %0d exp %0d", g.found, e.found));
            if (g.prog  !== e.prog)  report($sformatf("progress %0h exp %0h", g.prog, e.prog));
            if (g.tms   !== e.tms)   report($sformatf("time %0h exp %0h", g.tms, e.tms));
            if (g.speed !== e.speed) report($sformatf("speed %0h exp %0h", g.speed, e.speed));
            if (g.glat  !== e.glat)  report($sformatf("g_lat %0h exp %0h", g.glat, e.glat));
            if (g.glong !== e.glong) report($sformatf("g_long %0h exp %0h", g.glong, e.glong));
            if (g.accel !== e.accel) report($sformatf("accel %0h exp %0h", g.accel, e.accel));
            if (g.x     !== e.x)     report($sformatf("x %0h exp %0h", g.x, e.x));
            if (g.y     !== e.y)     report($sformatf("y %0h exp %0h", g.y, e.y));
            if (data[lti_pkg::TDATA_W-1:153] !== '0) report("tdata padding not zero");
        endtask
    endclass

    // ------------------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [lti_pkg::TDATA_W-1:0]   i_s_tdata;   // prog, time, speed, glat, glong, accel, x, y
    logic [1:0]                    i_s_tuser;   // action
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [lti_pkg::TDATA_W-1:0]   o_m_tdata;   // prog, time, speed, glat, glong, accel, x, y
    logic [0:0]                    o_m_tuser;   // found
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    lap_table_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;

    lap_trace_interpolator_unit u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser[0], o_m_tdata);
    end

    // tvalid stays up after a beat until the next beat; an idle cycle or a wait drops it
    task automatic send_item(t_lap_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.act;
        i_s_tdata  <= {7'd0, it.y, it.x, it.accel, it.glong, it.glat, it.speed, it.tms, it.prog};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(it);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_LAP_MS) sb.lap_ms = data[lti_pkg::TIME_W-1:0];
        else sb.edge_tol = data[lti_pkg::PROG_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic wait_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_lap_item make_item(lti_pkg::t_action act, int prog, int tms);
        t_lap_item it;
        it.act   = act;
        it.prog  = prog;
        it.tms   = tms;
        it.speed = $urandom();
        it.glat  = $urandom();
        it.glong = $urandom();
        it.accel = $urandom();
        it.x     = $urandom();
        it.y     = $urandom();
        return it;
    endfunction

    task automatic query(lti_pkg::t_action act, int v);
        send_item(make_item(act, act == lti_pkg::ACT_QPROG ? v : $urandom(),
                            act == lti_pkg::ACT_QTIME ? v : $urandom()));
    endtask

    task automatic append(int prog, int tms);
        send_item(make_item(lti_pkg::ACT_APPEND, prog, tms));
    endtask

    // clear, then a sorted table with a few out of order samples thrown in
    task automatic build_table(int n, int start_p, int start_t, int pstep, int tstep);
        int p;
        int t;
        p = start_p;
        t = start_t;
        query(lti_pkg::ACT_CLEAR, 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0 && p > 0) begin
                append($urandom_range(0, p - 1), $urandom_range(0, 16777215));
            end
            append(p, t);
            p = p + $urandom_range(0, pstep);
            if (p > 131071) p = 131071;
            if ($urandom_range(0, 15) == 0) t = $urandom_range(0, 16777215);
            else t = t + $urandom_range(0, tstep);
            if (t > 16777215) t = 16777215;
        end
    endtask

    task automatic random_queries(int q);
        int i;
        int v;
        for (int k = 0; k < q; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                if (sb.count > 0 && $urandom_range(0, 3) != 0) begin
                    i = $urandom_range(0, sb.count - 1);
                    v = int'(sb.p_tab[i]) + $urandom_range(0, 800) - 400;
                    if ($urandom_range(0, 7) == 0)
                        v = int'(sb.p_tab[i]) + ($urandom_range(0, 1) ? 1 : -1) *
                            int'(sb.edge_tol);
                    if (v < 0) v = 0;
                    if (v > 131071) v = 131071;
                end else begin
                    v = $urandom_range(0, 131071);
                end
                query(lti_pkg::ACT_QPROG, v);
            end else begin
                if (sb.count > 0 && $urandom_range(0, 3) != 0) begin
                    i = $urandom_range(0, sb.count - 1);
                    v = int'(sb.t_tab[i]) + $urandom_range(0, 4000) - 2000;
                    if (v < 0) v = 0;
                    if (v > 16777215) v = 16777215;
                end else begin
                    v = $urandom_range(0, 16777215);
                end
                query(lti_pkg::ACT_QTIME, v);
            end
        end
    endtask

    initial begin
        t_lap_item it;
        int        sent;
        int        set_no;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = lti_pkg::ACT_CLEAR;
        i_m_tready     = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = ADDR_LAP_MS;
        pwdata         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // directed: empty table, field extremes, edges of the covered range
        query(lti_pkg::ACT_QPROG, 0);
        query(lti_pkg::ACT_QTIME, 0);
        it = make_item(lti_pkg::ACT_APPEND, 1000, 100);
        it.speed = 16'sh8000; it.glat = 16'sh8000; it.glong = 16'sh8000;
        it.accel = 16'sh8000; it.x = 24'sh800000; it.y = 24'sh800000;
        send_item(it);
        query(lti_pkg::ACT_QPROG, 1000);          // first entry hit
        query(lti_pkg::ACT_QTIME, 100);           // single sample: no pair
        it = make_item(lti_pkg::ACT_APPEND, 3000, 500);
        it.speed = 16'sh7fff; it.glat = 16'sh7fff; it.glong = 16'sh7fff;
        it.accel = 16'sh7fff; it.x = 24'sh7fffff; it.y = 24'sh7fffff;
        send_item(it);
        append(2000, 300);               // out of order, dropped
        append(3000, 500);               // zero span pair
        query(lti_pkg::ACT_QPROG, 2000);
        query(lti_pkg::ACT_QPROG, 2001);
        query(lti_pkg::ACT_QPROG, 672);
        query(lti_pkg::ACT_QPROG, 671);
        query(lti_pkg::ACT_QPROG, 3328);
        query(lti_pkg::ACT_QPROG, 3329);
        query(lti_pkg::ACT_QTIME, 300);
        query(lti_pkg::ACT_QTIME, 500);
        query(lti_pkg::ACT_QTIME, 99);
        append(65536, 16777215);
        query(lti_pkg::ACT_QPROG, 65536);
        query(lti_pkg::ACT_QPROG, 65864);
        query(lti_pkg::ACT_QTIME, 16777215);
        drain();
        apb_write(ADDR_LAP_MS, 32'hffffff);
        apb_write(ADDR_EDGE_TOL, 32'd65536);
        query(lti_pkg::ACT_QPROG, 131071);        // past last at full lap: lap time not above last time, no lerp
        query(lti_pkg::ACT_QPROG, 60000);
        sent = 25;

        // full table; the extra samples are dropped, time queries near the end scan it all
        drain();
        apb_write(ADDR_EDGE_TOL, 32'd0);
        query(lti_pkg::ACT_CLEAR, 0);
        for (int i = 0; i < TABLE_DEPTH + 3; i++) append(i * 60, i * 16000);
        query(lti_pkg::ACT_QPROG, 61379);
        query(lti_pkg::ACT_QPROG, 61381);
        query(lti_pkg::ACT_QTIME, 16368000);
        query(lti_pkg::ACT_QTIME, 16367999);
        query(lti_pkg::ACT_QTIME, 8000);
        sent += TABLE_DEPTH + 9;

        set_no = 0;
        while (sent < 1950) begin
            if (set_no % 6 == 0) begin
                drain();
                case ((set_no / 6) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                    default: begin send_idle_pct = 7; recv_stall_pct = 7; end
                endcase
                case ($urandom_range(0, 3))
                    0: apb_write(ADDR_LAP_MS, 32'd0);
                    1: apb_write(ADDR_LAP_MS, 32'hffffff);
                    default: apb_write(ADDR_LAP_MS, $urandom_range(0, 16777215));
                endcase
                case ($urandom_range(0, 3))
                    0: apb_write(ADDR_EDGE_TOL, 32'd0);
                    1: apb_write(ADDR_EDGE_TOL, 32'd65536);
                    2: apb_write(ADDR_EDGE_TOL, 32'd328);
                    default: apb_write(ADDR_EDGE_TOL, $urandom_range(0, 65536));
                endcase
            end
            if (set_no == 3) hold_request = 400;
            // sender waits for every result before going on
            if (set_no == 9) wait_results();
            begin
                int n;
                int q;
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                q = $urandom_range(4, 16);
                build_table(n, $urandom_range(0, 70000), $urandom_range(0, 16000000),
                            $urandom_range(0, 1) ? 3000 : 400, 5000);
                random_queries(q);
                sent += n + q + 1;
            end
            set_no++;
        end

        drain();
        if (sb.pending.size() != 0) sb.report("expected results left over");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> lap_trace_interpolator_unit.f
hw/rtl/lti_pkg.sv
hw/rtl/lti_ram.sv
hw/rtl/lap_trace_interpolator_unit.sv
hw/rtl/lti_checker.sv
tb/lap_trace_interpolator_unit_test.sv
